// ===== src/pure_pursuit_velocity_command_defines.svh =====
// Assertion macros for the pure-pursuit velocity command block.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef PURE_PURSUIT_VELOCITY_COMMAND_DEFINES_SVH
`define PURE_PURSUIT_VELOCITY_COMMAND_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPVC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== src/ppvc_pkg.sv =====
// Package for the pure-pursuit velocity command block: types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package ppvc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 31;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DESIRED_SPEED = 3'd0,
		REG_MAX_ACCEL     = 3'd1,
		REG_MAX_DECEL     = 3'd2,
		REG_MIN_LOOKAHEAD = 3'd3,
		REG_MAX_LOOKAHEAD = 3'd4,
		REG_LOOKAHEAD_GAIN = 3'd5,
		REG_MAX_TURN_RATE = 3'd6,
		REG_SLOW_THRESHOLD = 3'd7
	} cfg_idx_t;

	localparam logic [CfgW-1:0] RST_DESIRED_SPEED  = 31'd32768;
	localparam logic [CfgW-1:0] RST_MAX_ACCEL      = 31'd65536;
	localparam logic [CfgW-1:0] RST_MAX_DECEL      = 31'd65536;
	localparam logic [CfgW-1:0] RST_MIN_LOOKAHEAD  = 31'd19661;
	localparam logic [CfgW-1:0] RST_MAX_LOOKAHEAD  = 31'd39322;
	localparam logic [CfgW-1:0] RST_LOOKAHEAD_GAIN = 31'd98304;
	localparam logic [CfgW-1:0] RST_MAX_TURN_RATE  = 31'd65536;
	localparam logic [CfgW-1:0] RST_SLOW_THRESHOLD = 31'd6554;

	localparam logic [31:0] DIST_EPS = 32'd65;
	localparam logic [31:0] SAT31    = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_FLAG = 32'h8000_0000;
	localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

	localparam logic [6:0] DIV_STEPS  = 7'd80;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LA_MUL, ST_LA_SET, ST_SQX, ST_SQY, ST_SQL, ST_TEST,
		ST_CX, ST_CY, ST_CSUM, ST_SQRT, ST_ANG_MUL, ST_ANG_LOAD, ST_DIV,
		ST_ANG_DONE, ST_ERR, ST_LIN_LOAD, ST_LIN_DONE, ST_MUL_UP, ST_MUL_DN,
		ST_SAVE_DN, ST_RL_LIN, ST_RL_ANG, ST_FINISH
	} state_t;

	function automatic logic [31:0] abs32(input logic [31:0] v);
		abs32 = v[31] ? (32'd0 - v) : v;
	endfunction

	// Rate limit v against p: up/dn are Q19.32 speed steps.
	function automatic logic signed [39:0] rate_lim(input logic signed [39:0] v,
			input logic signed [39:0] p, input logic [50:0] up, input logic [50:0] dn);
		logic signed [63:0] diff_s;
		logic signed [63:0] up_s;
		logic signed [63:0] dn_s;
		logic signed [39:0] r;
		diff_s = (64'(v) - 64'(p)) <<< 16;
		up_s   = $signed({13'd0, up});
		dn_s   = $signed({13'd0, dn});
		r      = v;
		if (diff_s > up_s)
			r = p + $signed({5'd0, up[50:16]});
		else if (diff_s < -dn_s)
			r = p - $signed({5'd0, dn[50:16]});
		return r;
	endfunction

endpackage

// ===== src/pure_pursuit_velocity_command.sv =====
// Top level of the pure-pursuit velocity command block: sequencer, shared
// multiplier, shared divider and square-root unit. Depends on ppvc_pkg and
// pure_pursuit_velocity_command_defines.svh.
`timescale 1ns / 1ps
`include "pure_pursuit_velocity_command_defines.svh"
//
// Usage
//  - Path points (robot frame, Q16.16) arrive one beat at a time: a beat is
//    taken at a clock edge with start high and busy low. The first beat of a
//    run samples current_speed and latches the lookahead distance; the beat
//    with last_point high closes the run and produces one command.
//  - Results leave on linear_cmd / angular_cmd, marked by done for exactly one
//    cycle. The receiver cannot stall; a result is simply presented once.
//  - Configuration: cfg_we writes cfg_data into register cfg_index at the
//    clock edge; write only while busy is low and no command is pending.
//  - Timing: one 32x32 multiplier, one restoring divider (one quotient bit
//    per cycle) and one square-root stage (one result bit per cycle). An
//    ordinary point is squared and tested before the next beat is taken (a
//    run's first point sets the lookahead first). A last point keeps busy
//    high through the square root, up to two divides and the rate limit;
//    done rises in the same cycle as busy drops. A divide is skipped when
//    the carrot is within the distance epsilon or no slowdown applies.
//  - Reset (arst_n low) drops any run in progress, clears the previous
//    command to zero and restores all configuration registers to defaults.
module pure_pursuit_velocity_command (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          point_x,
	input  logic signed [31:0]          point_y,
	input  logic signed [31:0]          current_speed,
	input  logic [19:0]                 time_step,
	input  logic                        last_point,
	output logic                        done,
	output logic [30:0]                 linear_cmd,
	output logic signed [31:0]          angular_cmd,
	input  logic                        cfg_we,
	input  logic [ppvc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ppvc_pkg::CfgW-1:0]   cfg_data
);
	import ppvc_pkg::*;

	// Configuration registers
	logic [30:0] des_q, acc_lim_q, dec_lim_q, min_la_q, max_la_q, gain_q, mtr_q, thr_q;

	// Sequencer
	state_t state_q, state_d;
	logic [6:0] cnt_q;

	// Item and run state
	logic [31:0] px_q, py_q, spd_q;
	logic [19:0] dt_q;
	logic        last_q;
	logic [30:0] la_q;
	logic        in_run_q, found_q;
	logic [31:0] carrot_x_q, carrot_y_q;
	logic [30:0] prev_lin_q;
	logic signed [31:0] prev_ang_q;

	// Shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q;
	logic [63:0] d2_q;

	// Square-root unit
	logic [63:0] sq_n_q, sq_r_q, sq_bit_q;
	logic [63:0] sq_t;

	// Divider
	logic [79:0] dvd_q;
	logic [63:0] dvs_q, rem_q;
	logic [31:0] quo_q;
	logic        div_ang_q;
	logic [64:0] rem_sh;
	logic [32:0] quo_sh;
	logic [31:0] quo_sat;

	// Result path
	logic signed [31:0] ang_q;
	logic [30:0]        lin_q;
	logic [50:0]        up_q, dn_q;
	logic signed [39:0] lin_rl_q, ang_rl_q;
	logic [31:0]        err;
	logic [47:0]        la_prod, la_tmp;
	logic signed [39:0] mtr_s, des_s;

	logic done_q;
	logic [30:0] linear_cmd_q;
	logic signed [31:0] angular_cmd_q;

	assign done        = done_q;
	assign linear_cmd  = linear_cmd_q;
	assign angular_cmd = angular_cmd_q;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			des_q     <= RST_DESIRED_SPEED;
			acc_lim_q <= RST_MAX_ACCEL;
			dec_lim_q <= RST_MAX_DECEL;
			min_la_q  <= RST_MIN_LOOKAHEAD;
			max_la_q  <= RST_MAX_LOOKAHEAD;
			gain_q    <= RST_LOOKAHEAD_GAIN;
			mtr_q     <= RST_MAX_TURN_RATE;
			thr_q     <= RST_SLOW_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_DESIRED_SPEED:  des_q     <= cfg_data;
				REG_MAX_ACCEL:      acc_lim_q <= cfg_data;
				REG_MAX_DECEL:      dec_lim_q <= cfg_data;
				REG_MIN_LOOKAHEAD:  min_la_q  <= cfg_data;
				REG_MAX_LOOKAHEAD:  max_la_q  <= cfg_data;
				REG_LOOKAHEAD_GAIN: gain_q    <= cfg_data;
				REG_MAX_TURN_RATE:  mtr_q     <= cfg_data;
				REG_SLOW_THRESHOLD: thr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Combinational helpers
	assign err = ({1'b0, la_q} > sq_r_q[31:0]) ? ({1'b0, la_q} - sq_r_q[31:0])
		: (sq_r_q[31:0] - {1'b0, la_q});
	assign sq_t   = sq_r_q + sq_bit_q;
	assign rem_sh = {rem_q, dvd_q[79]};
	assign quo_sh = {quo_q, (rem_sh >= {1'b0, dvs_q})};
	assign quo_sat = (quo_q > SAT31) ? SAT31 : quo_q;
	assign la_prod = mul_q[63:16];
	assign mtr_s = $signed({9'd0, mtr_q});
	assign des_s = $signed({9'd0, des_q});

	always_comb begin
		la_tmp = {17'd0, min_la_q};
		if (!spd_q[31] && (spd_q != 32'd0) && (la_prod > la_tmp))
			la_tmp = la_prod;
		if (la_tmp > {17'd0, max_la_q})
			la_tmp = {17'd0, max_la_q};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = in_run_q ? ST_SQX : ST_LA_MUL;
			ST_LA_MUL:   state_d = ST_LA_SET;
			ST_LA_SET:   state_d = ST_SQX;
			ST_SQX:      state_d = ST_SQY;
			ST_SQY:      state_d = ST_SQL;
			ST_SQL:      state_d = ST_TEST;
			ST_TEST:     state_d = last_q ? ST_CX : ST_IDLE;
			ST_CX:       state_d = ST_CY;
			ST_CY:       state_d = ST_CSUM;
			ST_CSUM:     state_d = ST_SQRT;
			ST_SQRT:     if (cnt_q == SQRT_STEPS - 7'd1) state_d = ST_ANG_MUL;
			ST_ANG_MUL:  state_d = (sq_r_q[31:0] > DIST_EPS) ? ST_ANG_LOAD : ST_ERR;
			ST_ANG_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_STEPS - 7'd1)
					state_d = div_ang_q ? ST_ANG_DONE : ST_LIN_DONE;
			end
			ST_ANG_DONE: state_d = ST_ERR;
			ST_ERR: begin
				state_d = ((err > {1'b0, thr_q}) && (la_q != '0)) ? ST_LIN_LOAD : ST_MUL_UP;
			end
			ST_LIN_LOAD: state_d = ST_DIV;
			ST_LIN_DONE: state_d = ST_MUL_UP;
			ST_MUL_UP:   state_d = ST_MUL_DN;
			ST_MUL_DN:   state_d = ST_SAVE_DN;
			ST_SAVE_DN:  state_d = ST_RL_LIN;
			ST_RL_LIN:   state_d = ST_RL_ANG;
			ST_RL_ANG:   state_d = ST_FINISH;
			ST_FINISH:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: busy flag and multiplier operands
	always_comb begin
		busy  = (state_q != ST_IDLE);
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_LA_MUL: begin
				mul_a = spd_q;
				mul_b = {1'b0, gain_q};
			end
			ST_SQX: begin
				mul_a = abs32(px_q);
				mul_b = abs32(px_q);
			end
			ST_SQY: begin
				mul_a = abs32(py_q);
				mul_b = abs32(py_q);
			end
			ST_SQL: begin
				mul_a = {1'b0, la_q};
				mul_b = {1'b0, la_q};
			end
			ST_CX: begin
				mul_a = abs32(carrot_x_q);
				mul_b = abs32(carrot_x_q);
			end
			ST_CY: begin
				mul_a = abs32(carrot_y_q);
				mul_b = abs32(carrot_y_q);
			end
			ST_ANG_MUL: begin
				mul_a = abs32(carrot_y_q);
				mul_b = {1'b0, des_q};
			end
			ST_ERR: begin
				mul_a = {1'b0, des_q};
				mul_b = err;
			end
			ST_MUL_UP: begin
				mul_a = {1'b0, acc_lim_q};
				mul_b = {12'd0, dt_q};
			end
			ST_MUL_DN: begin
				mul_a = {1'b0, dec_lim_q};
				mul_b = {12'd0, dt_q};
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			in_run_q      <= 1'b0;
			found_q       <= 1'b0;
			la_q          <= '0;
			carrot_x_q    <= '0;
			carrot_y_q    <= '0;
			prev_lin_q    <= '0;
			prev_ang_q    <= '0;
			done_q        <= 1'b0;
			linear_cmd_q  <= '0;
			angular_cmd_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_LA_SET: begin
					la_q     <= la_tmp[30:0];
					in_run_q <= 1'b1;
					found_q  <= 1'b0;
				end
				ST_TEST: begin
					// take the first point at or beyond lookahead, else the last one
					if (!found_q && ((d2_q >= mul_q) || last_q)) begin
						found_q    <= 1'b1;
						carrot_x_q <= px_q;
						carrot_y_q <= py_q;
					end
				end
				ST_CSUM:     cnt_q <= '0;
				ST_SQRT:     cnt_q <= cnt_q + 7'd1;
				ST_ANG_LOAD: cnt_q <= '0;
				ST_LIN_LOAD: cnt_q <= '0;
				ST_DIV:      cnt_q <= cnt_q + 7'd1;
				ST_FINISH: begin
					// clamp, remember as previous command, emit one beat
					if (ang_rl_q > mtr_s) begin
						prev_ang_q    <= 32'(mtr_s);
						angular_cmd_q <= 32'(mtr_s);
					end else if (ang_rl_q < -mtr_s) begin
						prev_ang_q    <= 32'(-mtr_s);
						angular_cmd_q <= 32'(-mtr_s);
					end else begin
						prev_ang_q    <= ang_rl_q[31:0];
						angular_cmd_q <= ang_rl_q[31:0];
					end
					if (lin_rl_q < 40'sd0) begin
						prev_lin_q   <= '0;
						linear_cmd_q <= '0;
					end else if (lin_rl_q > des_s) begin
						prev_lin_q   <= des_q;
						linear_cmd_q <= des_q;
					end else begin
						prev_lin_q   <= lin_rl_q[30:0];
						linear_cmd_q <= lin_rl_q[30:0];
					end
					in_run_q <= 1'b0;
					found_q  <= 1'b0;
					done_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			ST_IDLE: begin
				px_q   <= point_x;
				py_q   <= point_y;
				spd_q  <= current_speed;
				dt_q   <= time_step;
				last_q <= last_point;
			end
			ST_SQY:  d2_q <= mul_q;
			ST_SQL:  d2_q <= d2_q + mul_q;
			ST_CY:   d2_q <= mul_q;
			ST_CSUM: begin
				d2_q     <= d2_q + mul_q;
				sq_n_q   <= d2_q + mul_q;
				sq_r_q   <= '0;
				sq_bit_q <= SQRT_TOP_BIT;
			end
			ST_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_ANG_MUL: ang_q <= '0;
			ST_ANG_LOAD: begin
				// 2*|y|*v scaled by 2^16, over d^2
				dvd_q     <= {mul_q[62:0], 1'b0, 16'd0};
				dvs_q     <= d2_q;
				rem_q     <= '0;
				quo_q     <= '0;
				div_ang_q <= 1'b1;
			end
			ST_ERR: lin_q <= des_q;
			ST_LIN_LOAD: begin
				dvd_q     <= {16'd0, mul_q};
				dvs_q     <= {33'd0, la_q};
				rem_q     <= '0;
				quo_q     <= '0;
				div_ang_q <= 1'b0;
			end
			ST_DIV: begin
				if (quo_sh[0])
					rem_q <= rem_sh[63:0] - dvs_q;
				else
					rem_q <= rem_sh[63:0];
				// saturate the quotient once it passes 31 bits
				quo_q <= (quo_sh[32:31] != 2'b00) ? SAT_FLAG : quo_sh[31:0];
				dvd_q <= {dvd_q[78:0], 1'b0};
			end
			ST_ANG_DONE: ang_q <= carrot_y_q[31] ? (32'sd0 - $signed(quo_sat)) : $signed(quo_sat);
			ST_LIN_DONE: lin_q <= quo_sat[30:0];
			ST_MUL_DN:   up_q  <= mul_q[50:0];
			ST_SAVE_DN:  dn_q  <= mul_q[50:0];
			ST_RL_LIN: begin
				lin_rl_q <= rate_lim($signed({9'd0, lin_q}), $signed({9'd0, prev_lin_q}),
					up_q, dn_q);
			end
			ST_RL_ANG: begin
				ang_rl_q <= rate_lim(40'(ang_q), 40'(prev_ang_q), up_q, dn_q);
			end
			default: ;
		endcase
	end

	`PPVC_ASSERT_NEXT(a_finish_strobes, state_q == ST_FINISH, done_q, "finish without done")
	`PPVC_ASSERT_NEXT(a_done_single, done_q, !done_q, "done held more than one cycle")
	`PPVC_ASSERT_NOW(a_done_idle, done_q, !busy, "done while still busy")
	`PPVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

endmodule

// ===== verif/pure_pursuit_velocity_command_tb.sv =====
// Self-checking testbench for the pure-pursuit velocity command block.
// Depends on ppvc_pkg and the pure_pursuit_velocity_command RTL only.
`timescale 1ns / 1ps
module pure_pursuit_velocity_command_tb;
	import ppvc_pkg::*;

	typedef struct {
		logic [30:0]        lin;
		logic signed [31:0] ang;
	} velocity_cmd_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [31:0]    point_x;
	logic signed [31:0]    point_y;
	logic signed [31:0]    current_speed;
	logic [19:0]           time_step;
	logic                  last_point;
	logic                  done;
	logic [30:0]           linear_cmd;
	logic signed [31:0]    angular_cmd;
	logic                  cfg_we;
	logic [CfgIdxW-1:0]    cfg_index;
	logic [CfgW-1:0]       cfg_data;

	// Shadow of the register file and of the pursuit state
	logic [30:0]        regs [8];
	logic [31:0]        la_latched;
	logic               run_open;
	logic               carrot_held;
	logic signed [31:0] carrot_px;
	logic signed [31:0] carrot_py;
	longint             last_lin;
	longint             last_ang;

	velocity_cmd_t pending_cmds[$];
	int            errors;
	int            burst_left;
	int            idle_cycles;

	pure_pursuit_velocity_command uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.current_speed(current_speed),
		.time_step    (time_step),
		.last_point   (last_point),
		.done         (done),
		.linear_cmd   (linear_cmd),
		.angular_cmd  (angular_cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor square root, one result bit per pass from the top.
	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = 64'd0;
		for (int i = 31; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if (c * c <= n)
				r = c;
		end
		return r;
	endfunction

	// Clamp a speed change to what the acceleration limits allow over dt.
	function automatic longint slew_limit(input longint v, input longint p, input longint dt);
		longint diff;
		longint up;
		longint dn;
		diff = v - p;
		up   = longint'(regs[REG_MAX_ACCEL]) * dt;
		dn   = longint'(regs[REG_MAX_DECEL]) * dt;
		if (diff * 65536 > up)
			v = p + up / 65536;
		else if (diff * 65536 < -dn)
			v = p - dn / 65536;
		return v;
	endfunction

	// Advance the pursuit state by one point; return 1 when a command results.
	function automatic bit pursuit_step(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] spd, input logic [19:0] dt, input logic last,
			output velocity_cmd_t cmd);
		logic [63:0]  la;
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [63:0]  d2;
		logic [63:0]  carrot_dist;
		logic [63:0]  lref;
		logic [63:0]  err;
		logic [63:0]  lin_u;
		logic [79:0]  quo;
		longint       lin;
		longint       ang;
		longint       mtr;
		if (!run_open) begin
			la = 64'(regs[REG_MIN_LOOKAHEAD]);
			if (spd > 0) begin
				lin_u = (64'(spd) * 64'(regs[REG_LOOKAHEAD_GAIN])) >> 16;
				if (lin_u > la)
					la = lin_u;
			end
			if (la > regs[REG_MAX_LOOKAHEAD])
				la = 64'(regs[REG_MAX_LOOKAHEAD]);
			la_latched  = la[31:0];
			run_open    = 1'b1;
			carrot_held = 1'b0;
		end
		ax   = px[31] ? 64'(-longint'(px)) : 64'(px);
		ay   = py[31] ? 64'(-longint'(py)) : 64'(py);
		d2   = ax * ax + ay * ay;
		lref = 64'(la_latched);
		if (!carrot_held && (d2 >= lref * lref || last)) begin
			carrot_held = 1'b1;
			carrot_px   = px;
			carrot_py   = py;
		end
		if (!last)
			return 1'b0;

		ax   = carrot_px[31] ? 64'(-longint'(carrot_px)) : 64'(carrot_px);
		ay   = carrot_py[31] ? 64'(-longint'(carrot_py)) : 64'(carrot_py);
		d2   = ax * ax + ay * ay;
		carrot_dist = root_floor(d2);

		// Curvature toward the carrot, dropped when the carrot sits on the robot
		ang = 0;
		if (carrot_dist > 64'(DIST_EPS)) begin
			quo = {2 * ay * 64'(regs[REG_DESIRED_SPEED]), 16'd0} / 80'(d2);
			if (quo > 80'(SAT31))
				quo = 80'(SAT31);
			ang = carrot_py[31] ? -longint'(quo) : longint'(quo);
		end

		// Slow down as the carrot distance departs from the lookahead
		lin_u = 64'(regs[REG_DESIRED_SPEED]);
		err   = (lref > carrot_dist) ? lref - carrot_dist : carrot_dist - lref;
		if (err > regs[REG_SLOW_THRESHOLD] && lref != 0) begin
			lin_u = (64'(regs[REG_DESIRED_SPEED]) * err) / lref;
			if (lin_u > 64'(SAT31))
				lin_u = 64'(SAT31);
		end
		lin = longint'(lin_u);

		lin = slew_limit(lin, last_lin, longint'(dt));
		ang = slew_limit(ang, last_ang, longint'(dt));
		mtr = longint'(regs[REG_MAX_TURN_RATE]);
		if (ang > mtr)
			ang = mtr;
		if (ang < -mtr)
			ang = -mtr;
		if (lin < 0)
			lin = 0;
		if (lin > longint'(regs[REG_DESIRED_SPEED]))
			lin = longint'(regs[REG_DESIRED_SPEED]);

		last_lin    = lin;
		last_ang    = ang;
		run_open    = 1'b0;
		carrot_held = 1'b0;
		cmd.lin     = lin[30:0];
		cmd.ang     = ang[31:0];
		return 1'b1;
	endfunction

	// Compare every command strobe with the oldest prediction.
	always @(posedge clk) begin
		velocity_cmd_t want;
		if (arst_n && done) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command lin=%h ang=%h", $time, linear_cmd,
					angular_cmd);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				if (linear_cmd !== want.lin) begin
					$display("%0t: linear_cmd expected %h actual %h", $time, want.lin,
						linear_cmd);
					errors++;
				end
				if (angular_cmd !== want.ang) begin
					$display("%0t: angular_cmd expected %h actual %h", $time, want.ang,
						angular_cmd);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("** pure_pursuit_velocity_command: FAILED **");
			$finish;
		end
	end

	// Hold start low for a pause; n sets its length.
	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Send one path point as a beat and record its predicted command.
	task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] spd, input logic [19:0] dt, input logic last);
		velocity_cmd_t cmd;
		start         <= 1'b1;
		point_x       <= px;
		point_y       <= py;
		current_speed <= spd;
		time_step     <= dt;
		last_point    <= last;
		do @(posedge clk); while (busy);
		if (pursuit_step(px, py, spd, dt, last, cmd))
			pending_cmds.push_back(cmd);
	endtask

	// Drain all commands and let the block go quiet before touching registers.
	task automatic drain();
		start <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Present one register write for one cycle; the caller drops the enable.
	task automatic write_reg(input cfg_idx_t idx, input logic [30:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		regs[idx] = val;
	endtask

	task automatic load_regs(input logic [30:0] spd, input logic [30:0] acc,
			input logic [30:0] dec, input logic [30:0] la_min, input logic [30:0] la_max,
			input logic [30:0] gain, input logic [30:0] turn, input logic [30:0] thr);
		drain();
		write_reg(REG_DESIRED_SPEED, spd);
		write_reg(REG_MAX_ACCEL, acc);
		write_reg(REG_MAX_DECEL, dec);
		write_reg(REG_MIN_LOOKAHEAD, la_min);
		write_reg(REG_MAX_LOOKAHEAD, la_max);
		write_reg(REG_LOOKAHEAD_GAIN, gain);
		write_reg(REG_MAX_TURN_RATE, turn);
		write_reg(REG_SLOW_THRESHOLD, thr);
		cfg_we <= 1'b0;
	endtask

	// Coordinates: mostly near the lookahead scale, sometimes anywhere.
	function automatic logic signed [31:0] rand_coord();
		int mode;
		logic signed [31:0] v;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			v = $urandom;
		else if (mode < 3)
			v = $urandom_range(0, 255);
		else
			v = $urandom_range(0, 1 << 18);
		if (mode != 0 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic logic signed [31:0] rand_speed();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return -$signed({1'b0, 31'($urandom_range(0, 1 << 18))});
			default: return $urandom_range(0, 1 << 18);
		endcase
	endfunction

	function automatic logic [19:0] rand_step();
		case ($urandom_range(0, 5))
			0: return 20'd0;
			1: return 20'($urandom);
			default: return 20'($urandom_range(1, 16384));
		endcase
	endfunction

	// Send one point; the sender runs in bursts with random gaps between them.
	task automatic send_bursty(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] spd, input logic [19:0] dt, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 15));
		end
		burst_left--;
		send_point(px, py, spd, dt, last);
	endtask

	// Random path runs: mostly short well-formed runs, some long ones.
	task automatic test_random_runs(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				send_bursty(rand_coord(), rand_coord(), rand_speed(), rand_step(),
					k == len - 1);
				sent++;
			end
		end
	endtask

	// Directed points at reset defaults: edges of every field and the corner cases.
	task automatic test_directed_defaults();
		// single-point run with the carrot on the robot
		send_point(32'sd0, 32'sd0, 32'sd0, 20'd65536, 1'b1);
		send_point(32'sd40, -32'sd30, 32'sd65536, 20'd65536, 1'b1);
		// extreme coordinates and speed, largest step
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF, 1'b1);
		// negative speed, carrot found mid-run, zero step holds the last command
		send_point(32'sd100, 32'sd100, -32'sd65536, 20'd0, 1'b0);
		send_point(32'sd30000, -32'sd20000, 32'sd0, 20'd0, 1'b0);
		send_point(32'sd90000, 32'sd90000, 32'sd0, 20'd0, 1'b1);
		// no point reaches the lookahead: last point becomes the carrot
		send_point(32'sd10, 32'sd10, 32'sd65536, 20'd1000, 1'b0);
		send_point(-32'sd20, 32'sd5000, 32'sd65536, 20'd1000, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'sd1, 20'd1, 1'b1);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd65536, 1'b1);
	endtask

	// Lookahead clamp corners: min above max, then zero lookahead.
	task automatic test_lookahead_corners();
		load_regs(31'd65536, 31'd131072, 31'd65536, 31'd100000, 31'd30000, 31'd98304,
			31'd131072, 31'd6554);
		send_point(32'sd20000, 32'sd20000, 32'sd131072, 20'd65536, 1'b0);
		send_point(32'sd50000, -32'sd1000, 32'sd0, 20'd65536, 1'b1);
		load_regs(31'd65536, 31'd65536, 31'd65536, 31'd0, 31'd0, 31'd0, 31'd65536, 31'd0);
		send_point(32'sd0, 32'sd0, 32'sd65536, 20'd65536, 1'b0);
		send_point(32'sd60000, 32'sd30000, 32'sd0, 20'd65536, 1'b1);
		send_point(32'sd30, 32'sd30, 32'sd0, 20'd65536, 1'b1);
	endtask

	initial begin
		errors        = 0;
		burst_left    = 0;
		idle_cycles   = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		point_x       = '0;
		point_y       = '0;
		current_speed = '0;
		time_step     = '0;
		last_point    = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		regs[REG_DESIRED_SPEED]  = RST_DESIRED_SPEED;
		regs[REG_MAX_ACCEL]      = RST_MAX_ACCEL;
		regs[REG_MAX_DECEL]      = RST_MAX_DECEL;
		regs[REG_MIN_LOOKAHEAD]  = RST_MIN_LOOKAHEAD;
		regs[REG_MAX_LOOKAHEAD]  = RST_MAX_LOOKAHEAD;
		regs[REG_LOOKAHEAD_GAIN] = RST_LOOKAHEAD_GAIN;
		regs[REG_MAX_TURN_RATE]  = RST_MAX_TURN_RATE;
		regs[REG_SLOW_THRESHOLD] = RST_SLOW_THRESHOLD;
		la_latched  = '0;
		run_open    = 1'b0;
		carrot_held = 1'b0;
		carrot_px   = '0;
		carrot_py   = '0;
		last_lin    = 0;
		last_ang    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_defaults();
		test_lookahead_corners();

		// Defaults again, moderate random, register extremes, fully random registers, then a fixed mix
		load_regs(RST_DESIRED_SPEED, RST_MAX_ACCEL, RST_MAX_DECEL, RST_MIN_LOOKAHEAD,
			RST_MAX_LOOKAHEAD, RST_LOOKAHEAD_GAIN, RST_MAX_TURN_RATE, RST_SLOW_THRESHOLD);
		test_random_runs(260);
		load_regs(31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)),
			31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 17)),
			31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)),
			31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 14)));
		test_random_runs(260);
		load_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		test_random_runs(200);
		load_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
		test_random_runs(150);
		load_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
			31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
		test_random_runs(150);
		load_regs(31'd131072, 31'd32768, 31'd262144, 31'd13107, 31'd131072, 31'd65536,
			31'd98304, 31'd3277);
		test_random_runs(260);

		drain();
		repeat (250) @(posedge clk);
		if (errors == 0)
			$display("** pure_pursuit_velocity_command: PASSED **");
		else
			$display("** pure_pursuit_velocity_command: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/ppvc_pkg.sv
src/pure_pursuit_velocity_command.sv
verif/pure_pursuit_velocity_command_tb.sv
